// ----- src/nrid_pkg.sv -----
// shared types and constants for the nibble run-length image decoder
`timescale 1ns / 1ps
`default_nettype none
package nrid_pkg;

    localparam int DEF_CANVAS_WIDTH  = 320;
    localparam int DEF_CANVAS_HEIGHT = 200;

    localparam logic [2:0] PH_OP      = 3'd0;
    localparam logic [2:0] PH_ARG     = 3'd1;
    localparam logic [2:0] PH_LEN4    = 3'd2;
    localparam logic [2:0] PH_LEN2    = 3'd4;
    localparam logic [2:0] PH_LENLAST = 3'd5;
    localparam logic [2:0] PH_LENEND  = 3'd6;
    localparam logic [2:0] PH_LIT     = 3'd7;

    localparam logic [1:0] FS_DECODING = 2'd0;
    localparam logic [1:0] FS_DONE     = 2'd1;
    localparam logic [1:0] FS_ERROR    = 2'd2;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_COMPLETE = 3'd1;
    localparam logic [2:0] ST_IGNORED  = 3'd2;
    localparam logic [2:0] ST_EARLY    = 3'd3;
    localparam logic [2:0] ST_OVERRUN  = 3'd4;
    localparam logic [2:0] ST_TRANSP   = 3'd5;

    localparam logic [3:0] OP_SHORT_MAX = 4'h7;
    localparam logic [3:0] OP_FILL_B    = 4'h8;
    localparam logic [3:0] OP_LIT_B     = 4'h9;
    localparam logic [3:0] OP_SKIP      = 4'ha;
    localparam logic [3:0] OP_COPY_B    = 4'hb;
    localparam logic [3:0] OP_FILL_W    = 4'hc;
    localparam logic [3:0] OP_LIT_W     = 4'hd;
    localparam logic [3:0] OP_SKIP_LONG = 4'he;
    localparam logic [3:0] OP_COPY_W    = 4'hf;

    localparam logic [3:0] ARG_SKIP_SHORT_MAX = 4'hc;
    localparam logic [3:0] ARG_SKIP_LONG      = 4'he;
    localparam logic [3:0] ARG_SKIP_WORD      = 4'hf;

    localparam logic [16:0] SKIP_SHORT_BIAS = 17'd17;
    localparam logic [16:0] SKIP_LONG_BIAS  = 17'd257;

    typedef enum logic [1:0] {
        ACT_NEXT = 2'd0,
        ACT_STOP = 2'd1,
        ACT_FILL = 2'd2,
        ACT_COPY = 2'd3
    } nrid_act_t;

    typedef struct packed {
        logic clear;
        logic accept_byte;
        logic accept_read;
        logic nib;
        logic adv;
        logic fill;
        logic copy_rd;
        logic copy_wr;
        logic read_out;
        logic finish;
    } nrid_cmd_t;

    typedef struct packed {
        nrid_act_t act;
        logic      k;
        logic      pos_full;
        logic      pos_first_line;
        logic      run_last;
        logic      clear_done;
        logic      out_busy;
        logic      frame_dec;
    } nrid_sts_t;

endpackage
`default_nettype wire

// ----- src/nrid_ctrl.sv -----
// sequencing state machine of the decoder
`timescale 1ns / 1ps
`default_nettype none
module nrid_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic              operation,
    output logic                   in_ready,
    input  wire nrid_pkg::nrid_sts_t sts,
    output nrid_pkg::nrid_cmd_t    cmd
);
    import nrid_pkg::*;

    typedef enum logic [7:0] {
        S_CLEAR    = 8'b0000_0001,
        S_IDLE     = 8'b0000_0010,
        S_NIB      = 8'b0000_0100,
        S_FILL     = 8'b0000_1000,
        S_COPY_RD  = 8'b0001_0000,
        S_COPY_WR  = 8'b0010_0000,
        S_READ_OUT = 8'b0100_0000,
        S_FINISH   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (sts.clear_done)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (operation)
                    begin
                        cmd.accept_read = 1'b1;
                        state_next      = S_READ_OUT;
                    end
                    else
                    begin
                        cmd.accept_byte = 1'b1;
                        state_next      = sts.frame_dec ? S_NIB : S_FINISH;
                    end
                end
            end
            S_NIB:
            begin
                cmd.nib = 1'b1;
                unique case (sts.act)
                    ACT_STOP: state_next = S_FINISH;
                    ACT_FILL: state_next = S_FILL;
                    ACT_COPY: state_next = S_COPY_RD;
                    ACT_NEXT:
                    begin
                        if (sts.k)
                            state_next = S_FINISH;
                        else
                            cmd.adv = 1'b1;
                    end
                    default: state_next = S_FINISH;
                endcase
            end
            S_FILL:
            begin
                cmd.fill = 1'b1;
                if (sts.pos_full)
                    state_next = S_FINISH;
                else if (sts.run_last)
                begin
                    if (sts.k)
                        state_next = S_FINISH;
                    else
                    begin
                        cmd.adv    = 1'b1;
                        state_next = S_NIB;
                    end
                end
            end
            S_COPY_RD:
            begin
                cmd.copy_rd = 1'b1;
                state_next  = (sts.pos_full || sts.pos_first_line) ? S_FINISH : S_COPY_WR;
            end
            S_COPY_WR:
            begin
                cmd.copy_wr = 1'b1;
                state_next  = sts.run_last ? S_FILL : S_COPY_RD;
            end
            S_READ_OUT:
            begin
                if (!sts.out_busy)
                begin
                    cmd.read_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_FINISH:
            begin
                if (!sts.out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_CLEAR;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_CLEAR;
        else
            state_reg <= state_next;
    end

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.finish || cmd.read_out) |-> !sts.out_busy)
        else $error("result loaded over a waiting result");

    a_second_nib: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_NIB && sts.act == ACT_NEXT && !sts.k) |=>
        (state_reg == S_NIB && sts.k))
        else $error("low nibble not taken after high nibble");

endmodule
`default_nettype wire

// ----- src/nrid_datapath.sv -----
// parser registers, run engine, canvas memory and result register
`timescale 1ns / 1ps
`default_nettype none
module nrid_datapath #(
    parameter int CANVAS_WIDTH  = nrid_pkg::DEF_CANVAS_WIDTH,
    parameter int CANVAS_HEIGHT = nrid_pkg::DEF_CANVAS_HEIGHT
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_write_enable,
    input  wire logic                cfg_write_data,
    input  wire logic [7:0]          data_byte,
    input  wire logic                last_byte,
    input  wire logic [15:0]         pixel_address,
    input  wire nrid_pkg::nrid_cmd_t cmd,
    output nrid_pkg::nrid_sts_t      sts,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [2:0]               status,
    output logic [3:0]               pixel_value
);
    import nrid_pkg::*;

    localparam int PIXELS = CANVAS_WIDTH * CANVAS_HEIGHT;
    localparam int PW     = $clog2(PIXELS + 1);
    localparam int AW     = (PIXELS > 1) ? $clog2(PIXELS) : 1;
    localparam int SW     = (PW > 17) ? PW + 1 : 18;

    logic [3:0] mem [PIXELS];

    logic [PW-1:0] pos_reg, pos_next;
    logic [2:0]    phase_reg, phase_next;
    logic [3:0]    op_reg, op_next;
    logic [3:0]    arg_reg, arg_next;
    logic [16:0]   len_reg, len_next;
    logic [1:0]    frame_reg, frame_next;
    logic          delta_reg, delta_next;
    logic [7:0]    byte_reg, byte_next;
    logic          last_reg, last_next;
    logic          k_reg, k_next;
    logic [2:0]    st_reg, st_next;
    logic [16:0]   cnt_reg, cnt_next;
    logic [3:0]    col_reg, col_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic          rd_ok_reg, rd_ok_next;
    logic [3:0]    rd_data_reg;
    logic          out_valid_reg, out_valid_next;
    logic [2:0]    out_status_reg, out_status_next;
    logic [3:0]    out_pixel_reg, out_pixel_next;

    logic          we, re;
    logic [AW-1:0] waddr, raddr;
    logic [3:0]    wdata;
    logic [3:0]    nib;
    logic [16:0]   lenv, rem, skip_cnt;
    logic          do_skip;
    logic [PW-1:0] room, copy_src;
    logic [31:0]   ra32;
    logic          pos_full, first_line;
    logic [2:0]    fst;
    nrid_act_t     act;

    assign pos_full   = (pos_reg >= PW'(PIXELS));
    assign first_line = (pos_reg < PW'(CANVAS_WIDTH));
    assign room       = PW'(PIXELS) - pos_reg;
    assign copy_src   = pos_reg - PW'(CANVAS_WIDTH);
    assign ra32       = {16'd0, pixel_address};
    assign nib        = k_reg ? byte_reg[3:0] : byte_reg[7:4];
    assign lenv       = {len_reg[12:0], nib};

    always_comb
    begin
        pos_next        = pos_reg;
        phase_next      = phase_reg;
        op_next         = op_reg;
        arg_next        = arg_reg;
        len_next        = len_reg;
        frame_next      = frame_reg;
        delta_next      = delta_reg;
        byte_next       = byte_reg;
        last_next       = last_reg;
        k_next          = k_reg;
        st_next         = st_reg;
        cnt_next        = cnt_reg;
        col_next        = col_reg;
        clr_next        = clr_reg;
        rd_ok_next      = rd_ok_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_pixel_next  = out_pixel_reg;
        we              = 1'b0;
        re              = 1'b0;
        waddr           = pos_reg[AW-1:0];
        raddr           = copy_src[AW-1:0];
        wdata           = nib;
        act             = ACT_NEXT;
        do_skip         = 1'b0;
        skip_cnt        = '0;
        rem             = '0;
        fst             = st_reg;

        if (cfg_write_enable)
            delta_next = cfg_write_data;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        if (cmd.clear)
        begin
            we       = 1'b1;
            waddr    = clr_reg;
            wdata    = 4'd0;
            clr_next = clr_reg + AW'(1);
        end

        if (cmd.accept_read)
        begin
            re         = 1'b1;
            raddr      = ra32[AW-1:0];
            rd_ok_next = (ra32 < 32'(PIXELS));
        end

        if (cmd.accept_byte)
        begin
            byte_next = data_byte;
            last_next = last_byte;
            k_next    = 1'b0;
            st_next   = (frame_reg == FS_DECODING) ? ST_OK : ST_IGNORED;
        end

        if (cmd.adv)
            k_next = 1'b1;

        if (cmd.nib)
        begin
            if (phase_reg == PH_OP && pos_full)
            begin
                st_next = ST_COMPLETE;
                act     = ACT_STOP;
            end
            else
            begin
                unique case (phase_reg)
                    PH_OP:
                    begin
                        op_next    = nib;
                        phase_next = PH_ARG;
                    end
                    PH_ARG:
                    begin
                        arg_next   = nib;
                        phase_next = PH_OP;
                        len_next   = '0;
                        if (op_reg <= OP_SHORT_MAX)
                        begin
                            cnt_next = 17'(op_reg) + 17'd1;
                            col_next = nib;
                            act      = ACT_FILL;
                        end
                        else if (op_reg == OP_FILL_B || op_reg == OP_LIT_B
                                 || op_reg == OP_COPY_B)
                            phase_next = PH_LEN2;
                        else if (op_reg == OP_FILL_W || op_reg == OP_LIT_W
                                 || op_reg == OP_COPY_W)
                            phase_next = PH_LEN4;
                        else if (!delta_reg)
                        begin
                            st_next = ST_TRANSP;
                            act     = ACT_STOP;
                        end
                        else if (op_reg == OP_SKIP)
                        begin
                            do_skip  = 1'b1;
                            skip_cnt = 17'(nib) + 17'd1;
                        end
                        else if (nib <= ARG_SKIP_SHORT_MAX)
                        begin
                            do_skip  = 1'b1;
                            skip_cnt = 17'(nib) + SKIP_SHORT_BIAS;
                        end
                        else
                            phase_next = (nib == ARG_SKIP_WORD) ? PH_LEN4 : PH_LEN2;
                    end
                    PH_LIT:
                    begin
                        if (pos_full)
                        begin
                            st_next = ST_OVERRUN;
                            act     = ACT_STOP;
                        end
                        else
                        begin
                            we       = 1'b1;
                            wdata    = nib;
                            pos_next = pos_reg + PW'(1);
                            len_next = len_reg - 17'd1;
                            if (len_reg == 17'd1)
                                phase_next = PH_OP;
                        end
                    end
                    default:
                    begin
                        len_next = lenv;
                        if (phase_reg != PH_LENLAST)
                            phase_next = phase_reg + 3'd1;
                        else
                        begin
                            phase_next = PH_OP;
                            if (op_reg == OP_FILL_B || op_reg == OP_FILL_W)
                            begin
                                cnt_next = lenv + 17'd1;
                                col_next = arg_reg;
                                act      = ACT_FILL;
                            end
                            else if (op_reg == OP_COPY_B || op_reg == OP_COPY_W)
                            begin
                                cnt_next = lenv + 17'd1;
                                act      = ACT_COPY;
                            end
                            else if (op_reg == OP_LIT_B || op_reg == OP_LIT_W)
                            begin
                                if (!lenv[0])
                                begin
                                    if (pos_full)
                                    begin
                                        st_next = ST_OVERRUN;
                                        act     = ACT_STOP;
                                    end
                                    else
                                    begin
                                        we       = 1'b1;
                                        wdata    = arg_reg;
                                        pos_next = pos_reg + PW'(1);
                                        rem      = lenv;
                                    end
                                end
                                else
                                    rem = lenv + 17'd1;
                                if (act != ACT_STOP && rem != 17'd0)
                                begin
                                    len_next   = rem;
                                    phase_next = PH_LIT;
                                end
                            end
                            else
                            begin
                                do_skip  = 1'b1;
                                skip_cnt = lenv + ((arg_reg == ARG_SKIP_LONG) ?
                                           SKIP_LONG_BIAS : 17'd1);
                            end
                        end
                    end
                endcase
            end
            if (do_skip)
            begin
                if (SW'(skip_cnt) > SW'(room))
                begin
                    st_next = ST_OVERRUN;
                    act     = ACT_STOP;
                end
                else
                    pos_next = pos_reg + PW'(skip_cnt);
            end
        end

        if (cmd.fill)
        begin
            if (pos_full)
                st_next = ST_OVERRUN;
            else
            begin
                we       = 1'b1;
                wdata    = col_reg;
                pos_next = pos_reg + PW'(1);
                cnt_next = cnt_reg - 17'd1;
            end
        end

        if (cmd.copy_rd)
        begin
            if (pos_full || first_line)
                st_next = ST_OVERRUN;
            else
                re = 1'b1;
        end

        if (cmd.copy_wr)
        begin
            we       = 1'b1;
            wdata    = rd_data_reg;
            pos_next = pos_reg + PW'(1);
            cnt_next = cnt_reg - 17'd1;
            if (cnt_reg == 17'd1)
            begin
                cnt_next = 17'd1;
                col_next = arg_reg;
            end
        end

        if (cmd.read_out)
        begin
            out_valid_next  = 1'b1;
            out_status_next = ST_OK;
            out_pixel_next  = rd_ok_reg ? rd_data_reg : 4'd0;
        end

        if (cmd.finish)
        begin
            if (st_reg == ST_OK && phase_reg == PH_OP && pos_full)
                fst = ST_COMPLETE;
            if (fst == ST_COMPLETE)
                frame_next = FS_DONE;
            else if (fst != ST_OK)
                frame_next = FS_ERROR;
            else if (last_reg)
                fst = (phase_reg == PH_OP || phase_reg == PH_ARG) ? ST_EARLY : ST_OVERRUN;
            if (last_reg)
            begin
                pos_next   = '0;
                phase_next = PH_OP;
                op_next    = '0;
                arg_next   = '0;
                len_next   = '0;
                frame_next = FS_DECODING;
            end
            out_valid_next  = 1'b1;
            out_status_next = fst;
            out_pixel_next  = 4'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rd_data_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            phase_reg     <= PH_OP;
            op_reg        <= '0;
            arg_reg       <= '0;
            len_reg       <= '0;
            frame_reg     <= FS_DECODING;
            delta_reg     <= 1'b0;
            k_reg         <= 1'b0;
            st_reg        <= ST_OK;
            cnt_reg       <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            phase_reg     <= phase_next;
            op_reg        <= op_next;
            arg_reg       <= arg_next;
            len_reg       <= len_next;
            frame_reg     <= frame_next;
            delta_reg     <= delta_next;
            k_reg         <= k_next;
            st_reg        <= st_next;
            cnt_reg       <= cnt_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg       <= byte_next;
        last_reg       <= last_next;
        col_reg        <= col_next;
        rd_ok_reg      <= rd_ok_next;
        out_status_reg <= out_status_next;
        out_pixel_reg  <= out_pixel_next;
    end

    always_comb
    begin
        sts                = '0;
        sts.act            = act;
        sts.k              = k_reg;
        sts.pos_full       = pos_full;
        sts.pos_first_line = first_line;
        sts.run_last       = (cnt_reg == 17'd1);
        sts.clear_done     = (clr_reg == AW'(PIXELS - 1));
        sts.out_busy       = out_valid_reg && !out_ready;
        sts.frame_dec      = (frame_reg == FS_DECODING);
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign pixel_value = out_pixel_reg;

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= PW'(PIXELS))
        else $error("pixel position past canvas end");

    a_write_range: assert property (@(posedge clk) disable iff (!rst_n)
        we |-> ({1'b0, waddr} < (AW + 1)'(PIXELS)))
        else $error("canvas write outside canvas");

    a_lit_count: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_LIT) |-> (len_reg != 17'd0 && phase_reg != PH_LENEND))
        else $error("literal phase with no nibbles left");

endmodule
`default_nettype wire

// ----- src/nibble_rle_image_decoder.sv -----
// top level of the nibble run-length image decoder
//
//  channel   signals                                          direction
//  in        in_valid/in_ready, operation, data_byte,         request in
//            last_byte, pixel_address
//  out       out_valid/out_ready, status, pixel_value         request out
//  cfg       cfg_write_enable, cfg_write_data (delta_mode)    write only
//
// a byte request steps through accept, two nibbles and result load, plus a fill
// step per filled pixel and a read and a write step per copied pixel; an ignored
// byte skips the nibbles; reads use the registered canvas memory port
// after reset a clearing pass writes one canvas pixel a cycle, all 64000 pixels at
// the default size, and no request is taken until it ends
// a waiting result holds the block only when the next result is ready to load
`timescale 1ns / 1ps
`default_nettype none
module nibble_rle_image_decoder #(
    parameter int CANVAS_WIDTH  = nrid_pkg::DEF_CANVAS_WIDTH,
    parameter int CANVAS_HEIGHT = nrid_pkg::DEF_CANVAS_HEIGHT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write_enable,
    input  wire logic        cfg_write_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        operation,
    input  wire logic [7:0]  data_byte,
    input  wire logic        last_byte,
    input  wire logic [15:0] pixel_address,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       status,
    output logic [3:0]       pixel_value
);
    import nrid_pkg::*;

    nrid_cmd_t cmd;
    nrid_sts_t sts;

    nrid_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .operation (operation),
        .in_ready  (in_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    nrid_datapath #(
        .CANVAS_WIDTH  (CANVAS_WIDTH),
        .CANVAS_HEIGHT (CANVAS_HEIGHT)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_write_data   (cfg_write_data),
        .data_byte        (data_byte),
        .last_byte        (last_byte),
        .pixel_address    (pixel_address),
        .cmd              (cmd),
        .sts              (sts),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .status           (status),
        .pixel_value      (pixel_value)
    );

endmodule
`default_nettype wire

// ----- bench/tb_nibble_rle_image_decoder.sv -----
// testbench for the nibble run-length image decoder: directed and random requests checked against a predictor
`timescale 1ns / 1ps
`default_nettype none
module tb_nibble_rle_image_decoder;
    import nrid_pkg::*;

    localparam int PIXELS      = DEF_CANVAS_WIDTH * DEF_CANVAS_HEIGHT;
    localparam int CYCLE_LIMIT = 4000000;

    typedef struct packed {
        logic [2:0] status;
        logic [3:0] pixel_value;
    } decode_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write_enable = 1'b0;
    logic        cfg_write_data = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        operation = 1'b0;
    logic [7:0]  data_byte = 8'd0;
    logic        last_byte = 1'b0;
    logic [15:0] pixel_address = 16'd0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  status;
    logic [3:0]  pixel_value;

    nibble_rle_image_decoder u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write_enable(cfg_write_enable),
        .cfg_write_data(cfg_write_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .operation(operation),
        .data_byte(data_byte),
        .last_byte(last_byte),
        .pixel_address(pixel_address),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .status(status),
        .pixel_value(pixel_value)
    );

    always #6 clk = ~clk;

    // predictor state
    logic [3:0]  canvas_img [0:PIXELS-1];
    int unsigned draw_pos;
    logic [2:0]  parse_ph;
    logic [3:0]  op_nib;
    logic [3:0]  arg_nib;
    logic [16:0] len_acc;
    logic [1:0]  frame_st;
    logic        delta_on;

    decode_result_t pending_results[$];
    logic [3:0]     stream_nibs[$];
    int error_count;
    int request_count;
    int result_count;
    int complete_count;
    int cycle_count;
    int send_idle_pct;
    int recv_stall_pct;

    function automatic bit put_px(logic [3:0] colour);
        if (draw_pos >= PIXELS) return 1'b0;
        canvas_img[draw_pos] = colour;
        draw_pos++;
        return 1'b1;
    endfunction

    function automatic bit fill_run(int unsigned count, logic [3:0] colour);
        for (int unsigned i = 0; i < count; i++)
            if (!put_px(colour)) return 1'b0;
        return 1'b1;
    endfunction

    function automatic bit copy_above(int unsigned count);
        for (int unsigned i = 0; i < count; i++)
        begin
            if (draw_pos >= PIXELS || draw_pos < DEF_CANVAS_WIDTH) return 1'b0;
            canvas_img[draw_pos] = canvas_img[draw_pos - DEF_CANVAS_WIDTH];
            draw_pos++;
        end
        return 1'b1;
    endfunction

    function automatic logic [2:0] skip_px(int unsigned count);
        if (count > PIXELS - draw_pos) return ST_OVERRUN;
        draw_pos += count;
        return ST_OK;
    endfunction

    function automatic logic [2:0] run_with_len(int unsigned v);
        int unsigned rem;
        case (op_nib)
            OP_FILL_B, OP_FILL_W: return fill_run(v + 1, arg_nib) ? ST_OK : ST_OVERRUN;
            OP_COPY_B, OP_COPY_W:
                return (copy_above(v + 1) && put_px(arg_nib)) ? ST_OK : ST_OVERRUN;
            OP_LIT_B, OP_LIT_W:
            begin
                if (v[0] == 1'b0)
                begin
                    if (!put_px(arg_nib)) return ST_OVERRUN;
                    rem = v;
                end
                else
                    rem = v + 1;
                if (rem != 0)
                begin
                    len_acc = rem[16:0];
                    parse_ph = PH_LIT;
                end
                return ST_OK;
            end
            default:
                return skip_px(arg_nib == ARG_SKIP_LONG ? v + SKIP_LONG_BIAS : v + 1);
        endcase
    endfunction

    function automatic logic [2:0] take_nibble(logic [3:0] nib);
        case (parse_ph)
            PH_OP:
            begin
                op_nib = nib;
                parse_ph = PH_ARG;
                return ST_OK;
            end
            PH_ARG:
            begin
                arg_nib = nib;
                parse_ph = PH_OP;
                len_acc = '0;
                if (op_nib <= OP_SHORT_MAX)
                    return fill_run(op_nib + 1, nib) ? ST_OK : ST_OVERRUN;
                if (op_nib == OP_FILL_B || op_nib == OP_LIT_B || op_nib == OP_COPY_B)
                begin
                    parse_ph = PH_LEN2;
                    return ST_OK;
                end
                if (op_nib == OP_FILL_W || op_nib == OP_LIT_W || op_nib == OP_COPY_W)
                begin
                    parse_ph = PH_LEN4;
                    return ST_OK;
                end
                if (!delta_on) return ST_TRANSP;
                if (op_nib == OP_SKIP) return skip_px(nib + 1);
                if (nib <= ARG_SKIP_SHORT_MAX) return skip_px(nib + SKIP_SHORT_BIAS);
                parse_ph = (nib == ARG_SKIP_WORD) ? PH_LEN4 : PH_LEN2;
                return ST_OK;
            end
            PH_LIT:
            begin
                if (!put_px(nib)) return ST_OVERRUN;
                len_acc--;
                if (len_acc == 0) parse_ph = PH_OP;
                return ST_OK;
            end
            default:
            begin
                len_acc = {len_acc[12:0], nib};
                parse_ph++;
                if (parse_ph >= PH_LENEND)
                begin
                    parse_ph = PH_OP;
                    return run_with_len(len_acc);
                end
                return ST_OK;
            end
        endcase
    endfunction

    function automatic void start_frame();
        draw_pos = 0;
        parse_ph = PH_OP;
        op_nib = '0;
        arg_nib = '0;
        len_acc = '0;
        frame_st = FS_DECODING;
    endfunction

    function automatic decode_result_t predict_request(logic op, logic [7:0] b, logic last,
                                                       logic [15:0] addr);
        decode_result_t r;
        r.status = ST_OK;
        r.pixel_value = '0;
        if (op)
        begin
            if (addr < PIXELS) r.pixel_value = canvas_img[addr];
            return r;
        end
        if (frame_st != FS_DECODING)
            r.status = ST_IGNORED;
        else
        begin
            for (int k = 0; k < 2 && r.status == ST_OK; k++)
            begin
                if (parse_ph == PH_OP && draw_pos >= PIXELS)
                begin
                    r.status = ST_COMPLETE;
                    break;
                end
                r.status = take_nibble(k == 0 ? b[7:4] : b[3:0]);
            end
            if (r.status == ST_OK && parse_ph == PH_OP && draw_pos >= PIXELS)
                r.status = ST_COMPLETE;
            if (r.status == ST_COMPLETE)
                frame_st = FS_DONE;
            else if (r.status != ST_OK)
                frame_st = FS_ERROR;
            else if (last)
                r.status = (parse_ph == PH_OP || parse_ph == PH_ARG) ? ST_EARLY : ST_OVERRUN;
        end
        if (last) start_frame();
        return r;
    endfunction

    // result checker
    always @(posedge clk)
    begin
        decode_result_t exp_r;
        if (rst_n && out_valid && out_ready)
        begin
            result_count++;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result status %0d pixel %0d", $time, status,
                         pixel_value);
                error_count++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (status == ST_COMPLETE) complete_count++;
                if (status !== exp_r.status)
                begin
                    $display("%0t: status expected %0d actual %0d", $time, exp_r.status,
                             status);
                    error_count++;
                end
                if (pixel_value !== exp_r.pixel_value)
                begin
                    $display("%0t: pixel_value expected %0d actual %0d", $time,
                             exp_r.pixel_value, pixel_value);
                    error_count++;
                end
            end
        end
    end

    always @(negedge clk)
        out_ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_request(logic op, logic [7:0] b, logic last, logic [15:0] addr);
        int gap;
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            gap = $urandom_range(1, 6);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        operation <= op;
        data_byte <= b;
        last_byte <= last;
        pixel_address <= addr;
        do @(posedge clk); while (!in_ready);
        pending_results.push_back(predict_request(op, b, last, addr));
        request_count++;
        @(negedge clk);
    endtask

    task automatic send_byte(logic [7:0] b, logic last);
        send_request(1'b0, b, last, 16'($urandom_range(16'hffff)));
    endtask

    task automatic read_pixel(logic [15:0] addr);
        send_request(1'b1, 8'($urandom_range(255)), 1'($urandom_range(1)), addr);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_delta_mode(logic value);
        drain();
        cfg_write_enable <= 1'b1;
        cfg_write_data <= value;
        @(negedge clk);
        cfg_write_enable <= 1'b0;
        delta_on = value;
    endtask

    task automatic test_reads_after_reset();
        read_pixel(16'd0);
        read_pixel(16'd63999);
        read_pixel(16'd64000);
        read_pixel(16'hffff);
    endtask

    task automatic test_opcodes();
        logic [7:0] bytes[$];
        write_delta_mode(1'b0);
        // wide fill, short run, byte fill, copies, literals even and odd
        bytes = '{8'hc5, 8'h01, 8'h3f, 8'h73, 8'h82, 8'h05, 8'hb9, 8'h03, 8'h94, 8'h02,
                  8'hef, 8'h90, 8'h01, 8'h12, 8'hd7, 8'h00, 8'h03, 8'hab, 8'hcd,
                  8'hf1, 8'h00, 8'h02};
        foreach (bytes[i]) send_byte(bytes[i], 1'b0);
        send_byte(8'h00, 1'b1);
        read_pixel(16'd320);
        read_pixel(16'd335);
    endtask

    task automatic test_errors();
        send_byte(8'ha0, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'hb0, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'h81, 1'b1);
        write_delta_mode(1'b1);
        send_byte(8'ha3, 1'b0);
        send_byte(8'he5, 1'b0);
        send_byte(8'hed, 1'b0);
        send_byte(8'h10, 1'b0);
        send_byte(8'hee, 1'b0);
        send_byte(8'h02, 1'b0);
        send_byte(8'hef, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'h00, 1'b1);
    endtask

    task automatic test_completion();
        send_byte(8'hc9, 1'b0);
        send_byte(8'hf9, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'h00, 1'b1);
        read_pixel(16'd63999);
    endtask

    function automatic int pick_len(int wide);
        if ($urandom_range(99) < 85) return $urandom_range(30);
        if (wide > 255 && $urandom_range(99) < 3) return 16'hffff;
        return $urandom_range(wide);
    endfunction

    function automatic void push_len(int v, int count);
        for (int i = count - 1; i >= 0; i--) stream_nibs.push_back(4'((v >> (4 * i)) & 15));
    endfunction

    function automatic void add_command();
        int sel;
        int v;
        logic [3:0] arg;
        sel = $urandom_range(9);
        arg = 4'($urandom_range(15));
        case (sel)
            0, 9:
            begin
                stream_nibs.push_back(4'($urandom_range(7)));
                stream_nibs.push_back(arg);
            end
            1, 3:
            begin
                stream_nibs.push_back(sel == 1 ? OP_FILL_B : OP_COPY_B);
                stream_nibs.push_back(arg);
                push_len(pick_len(255), 2);
            end
            2, 4:
            begin
                stream_nibs.push_back(sel == 2 ? OP_FILL_W : OP_COPY_W);
                stream_nibs.push_back(arg);
                push_len(pick_len(2000), 4);
            end
            5, 6:
            begin
                stream_nibs.push_back(sel == 5 ? OP_LIT_B : OP_LIT_W);
                stream_nibs.push_back(arg);
                v = $urandom_range(12);
                push_len(v, sel == 5 ? 2 : 4);
                repeat (v[0] ? v + 1 : v) stream_nibs.push_back(4'($urandom_range(15)));
            end
            default:
            begin
                if (!delta_on && $urandom_range(3) != 0)
                begin
                    stream_nibs.push_back(4'($urandom_range(7)));
                    stream_nibs.push_back(arg);
                end
                else if (sel == 7)
                begin
                    stream_nibs.push_back(OP_SKIP);
                    stream_nibs.push_back(arg);
                end
                else
                begin
                    stream_nibs.push_back(OP_SKIP_LONG);
                    stream_nibs.push_back(arg);
                    if (arg == ARG_SKIP_WORD) push_len(pick_len(3000), 4);
                    else if (arg > ARG_SKIP_SHORT_MAX) push_len(pick_len(255), 2);
                end
            end
        endcase
    endfunction

    task automatic test_random_frames(int n_items, int idle_pct, int stall_pct);
        int sent;
        int kind;
        logic [7:0] b;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        sent = 0;
        while (sent < n_items)
        begin
            stream_nibs.delete();
            kind = $urandom_range(99);
            if (kind < 10)
                repeat ($urandom_range(1, 8)) stream_nibs.push_back(4'($urandom_range(15)));
            else if (kind < 14)
                push_len(int'(32'hc0f9ff | ($urandom_range(15) << 16)), 6);
            else
            begin
                // open with a wide fill so that later copies have a line above
                if ($urandom_range(3) != 0)
                begin
                    stream_nibs.push_back(OP_FILL_W);
                    stream_nibs.push_back(4'($urandom_range(15)));
                    push_len($urandom_range(319, 700), 4);
                end
                repeat ($urandom_range(2, 10)) add_command();
                if ($urandom_range(4) == 0)
                    repeat ($urandom_range(1, 4))
                        stream_nibs.push_back(4'($urandom_range(15)));
            end
            if (stream_nibs.size() % 2) stream_nibs.push_back(4'($urandom_range(15)));
            while (stream_nibs.size() != 0)
            begin
                b = {stream_nibs.pop_front(), stream_nibs.pop_front()};
                if ($urandom_range(99) < 15)
                begin
                    read_pixel($urandom_range(3) == 0 ? 16'($urandom_range(16'hffff))
                                                      : 16'($urandom_range(1500)));
                    sent++;
                end
                send_byte(b, stream_nibs.size() == 0);
                sent++;
            end
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    initial
    begin
        error_count = 0;
        request_count = 0;
        result_count = 0;
        complete_count = 0;
        cycle_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        for (int i = 0; i < PIXELS; i++) canvas_img[i] = '0;
        delta_on = 1'b0;
        start_frame();
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reads_after_reset();
        test_opcodes();
        test_errors();
        test_completion();
        write_delta_mode(1'b0);
        test_random_frames(130, 0, 0);
        write_delta_mode(1'b1);
        test_random_frames(130, 45, 0);
        write_delta_mode(1'b0);
        test_random_frames(130, 0, 45);
        write_delta_mode(1'b1);
        test_random_frames(130, 24, 24);
        drain();
        repeat (20) @(negedge clk);

        $display("%0d requests sent, %0d results checked, %0d completed frames",
                 request_count, result_count, complete_count);
        $display("covered all opcodes, both delta modes, errors, reads and idle mixes");
        if (error_count == 0 && pending_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
`default_nettype wire
